// File: rtl/sers_pkg.sv
// ---------------------------------------------------------------------------
// sers_pkg: shared types and constants of the echo retrigger scheduler
// Operation codes, the per-slot memory entry, the update flags, the result
// record and the sequencer states.
// ---------------------------------------------------------------------------
package sers_pkg;

  localparam int IN_W  = 96;  // 92 bits of fields, padded to whole bytes
  localparam int OUT_W = 56;  // 52 bits of fields, padded to whole bytes

  localparam logic signed [16:0] VOLUME_FLOOR = -17'sd127;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_CREATE   = 2'd1,
    OP_STOP     = 2'd2,
    OP_STOP_ALL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [15:0]        bank;
    logic [15:0]        code;
    logic [15:0]        reload;
    logic [15:0]        countdown;
    logic [7:0]         total;
    logic [7:0]         remaining;
    logic [7:0]         first_dec;
    logic [7:0]         later_dec;
    logic signed [16:0] volume;
  } slot_entry_t;

  typedef struct packed {
    logic        emit;  // slot retriggers on this tick
    logic        keep;  // slot stays active afterwards
  } upd_flags_t;

  typedef struct packed {
    logic [15:0] volume;
    logic [15:0] code;
    logic [15:0] bank;
    logic [3:0]  slot;
  } result_t;

endpackage

// File: rtl/sound_echo_retrigger_scheduler.sv
// ---------------------------------------------------------------------------
// sound_echo_retrigger_scheduler: bank of echo slots that retrigger events
// Slot entries live in one synchronous memory; a tick walks it slot by slot.
// ---------------------------------------------------------------------------
// Usage. Commands arrive as words on the s_ channel, the operation in s_tuser.
// Create, stop and stop-all complete in the cycle that accepts them. A tick
// reads the slot memory one entry per cycle unless stalled and writes each
// updated entry back from the registered read data. It holds the command
// channel from acceptance through the walk over every slot to a closing step
// that hands over its final retrigger word if there is one. Retrigger words
// leave on the m_ channel in slot order; each word is held back until the
// next one is known, so that m_tlast marks the final word of the tick. A tick
// with no retrigger gives no word. When the receiver stalls, the walk stops on
// the next slot that would retrigger while a word is pending and resumes when
// the output register frees up; the next command is taken while the final word
// of a tick still waits at the output. Reset clears all slots to inactive and
// the bank mask to zero; the memory contents need no clearing, since an entry
// is used only after a create. The user must write the bank mask through cfg_we
// and cfg_wdata only while the block idles; the block does not enforce this.
// ---------------------------------------------------------------------------
module sound_echo_retrigger_scheduler #(
  parameter int SLOT_COUNT = 16,
  parameter int BANK_COUNT = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [15:0]                cfg_wdata,  // bank_present_mask
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // slot[3:0], bank[19:4], event_code[35:20], interval[51:36],
  // first_decrement[59:52], later_decrement[67:60], repeat_count[75:68],
  // start_volume[91:76], zero padding[95:92]
  input  logic [sers_pkg::IN_W-1:0]  s_tdata,
  input  logic [1:0]                 s_tuser,    // operation[1:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // out_slot[3:0], out_bank[19:4], out_code[35:20], out_volume[51:36],
  // zero padding[55:52]
  output logic [sers_pkg::OUT_W-1:0] m_tdata,
  output logic                       m_tlast
);
  import sers_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PW = SW + 1;

  state_t              state, state_next;
  logic [15:0]         bank_mask;
  logic [SLOT_COUNT-1:0] act;
  logic [SW-1:0]       cur;
  logic [PW-1:0]       rd_ptr;

  slot_entry_t         mem [SLOT_COUNT];
  slot_entry_t         rd_data;
  logic                rd_en;
  logic [SW-1:0]       rd_addr;
  logic                wr_en;
  logic [SW-1:0]       wr_addr;
  slot_entry_t         wr_data;

  result_t             pend;
  logic                pend_valid;
  result_t             out_word;

  op_t                 in_op;
  logic [3:0]          in_slot;
  logic [15:0]         in_bank;
  logic                in_accept;
  logic                in_ok;
  logic [SW-1:0]       in_idx;
  slot_entry_t         new_entry;

  slot_entry_t         upd_entry;
  upd_flags_t          upd;
  logic                cur_act;
  logic                out_free;
  logic                stall;

  logic                tick_go;
  logic                walk_go;
  logic                emit_go;
  logic                flush_go;
  logic                act_set;
  logic                act_clr_in;
  logic                act_clr_cur;
  logic                act_clr_all;

  function automatic logic bank_loaded(input logic [15:0] b, input logic [15:0] mask);
    return (b < 16'(BANK_COUNT)) && mask[b[3:0]];
  endfunction

  assign in_op     = op_t'(s_tuser);
  assign in_slot   = s_tdata[3:0];
  assign in_bank   = s_tdata[19:4];
  assign in_accept = s_tvalid && s_tready;
  assign in_ok     = bank_loaded(in_bank, bank_mask) && ({1'b0, in_slot} < 5'(SLOT_COUNT));
  assign in_idx    = in_slot[SW-1:0];

  always_comb begin
    new_entry.bank      = in_bank;
    new_entry.code      = s_tdata[35:20];
    new_entry.reload    = s_tdata[51:36];
    new_entry.countdown = 16'd1;
    new_entry.first_dec = s_tdata[59:52];
    new_entry.later_dec = s_tdata[67:60];
    new_entry.total     = s_tdata[75:68];
    new_entry.remaining = s_tdata[75:68];
    new_entry.volume    = {s_tdata[91], s_tdata[91:76]};
  end

  sers_slot_update u_update (
    .entry       (rd_data),
    .bank_loaded (bank_loaded(rd_data.bank, bank_mask)),
    .entry_next  (upd_entry),
    .flags       (upd)
  );

  assign cur_act  = act[cur];
  assign out_free = !m_tvalid || m_tready;
  assign stall    = cur_act && upd.emit && pend_valid && !out_free;

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = cur;
    wr_data     = upd_entry;
    tick_go     = 1'b0;
    walk_go     = 1'b0;
    emit_go     = 1'b0;
    flush_go    = 1'b0;
    act_set     = 1'b0;
    act_clr_in  = 1'b0;
    act_clr_cur = 1'b0;
    act_clr_all = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (in_accept) begin
          case (in_op)
            OP_TICK: begin
              tick_go    = 1'b1;
              rd_en      = 1'b1;
              state_next = ST_WALK;
            end
            OP_CREATE: begin
              if (in_ok) begin
                wr_en   = 1'b1;
                wr_addr = in_idx;
                wr_data = new_entry;
                act_set = 1'b1;
              end
            end
            OP_STOP: begin
              act_clr_in = in_ok;
            end
            OP_STOP_ALL: begin
              act_clr_all = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (!stall) begin
          if (cur_act) begin
            wr_en       = 1'b1;
            act_clr_cur = !upd.keep;
            emit_go     = upd.emit;
          end
          if (rd_ptr < PW'(SLOT_COUNT)) begin
            walk_go = 1'b1;
            rd_en   = 1'b1;
            rd_addr = rd_ptr[SW-1:0];
          end else begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          flush_go   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_mask  <= '0;
      act        <= '0;
      cur        <= '0;
      rd_ptr     <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        bank_mask <= cfg_wdata;
      end
      if (act_clr_all) begin
        act <= '0;
      end else if (act_set) begin
        act[in_idx] <= 1'b1;
      end else if (act_clr_in) begin
        act[in_idx] <= 1'b0;
      end else if (act_clr_cur) begin
        act[cur] <= 1'b0;
      end
      if (tick_go) begin
        cur    <= '0;
        rd_ptr <= PW'(1);
      end else if (walk_go) begin
        cur    <= rd_ptr[SW-1:0];
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (emit_go) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          m_tvalid <= 1'b1;
        end else if (m_tvalid && m_tready) begin
          m_tvalid <= 1'b0;
        end
      end else if (flush_go) begin
        pend_valid <= 1'b0;
        m_tvalid   <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // A retrigger waits in the pending register until the next one shows up,
  // or the walk ends; only then is it known whether it is the final word.
  always_ff @(posedge clk) begin
    if (emit_go) begin
      pend.slot   <= 4'(cur);
      pend.bank   <= rd_data.bank;
      pend.code   <= rd_data.code;
      pend.volume <= rd_data.volume[15:0];
      if (pend_valid) begin
        out_word <= pend;
        m_tlast  <= 1'b0;
      end
    end else if (flush_go) begin
      out_word <= pend;
      m_tlast  <= 1'b1;
    end
  end

  assign m_tdata = {4'd0, out_word.volume, out_word.code, out_word.bank, out_word.slot};

endmodule

// File: rtl/sers_slot_update.sv
// ---------------------------------------------------------------------------
// sers_slot_update: tick update of one active echo slot
// Counts the slot down, decides on a retrigger, steps the repeat counter and
// lowers the volume offset; reports whether the slot stays active.
// ---------------------------------------------------------------------------
module sers_slot_update (
  input  sers_pkg::slot_entry_t entry,
  input  logic                  bank_loaded,
  output sers_pkg::slot_entry_t entry_next,
  output sers_pkg::upd_flags_t  flags
);
  import sers_pkg::*;

  logic [15:0]        cd;
  logic [7:0]         rem;
  logic [7:0]         dec;
  logic signed [16:0] vol;
  logic signed [16:0] vol_new;

  always_comb begin
    cd      = entry.countdown - 16'd1;
    rem     = entry.remaining - 8'd1;
    vol     = entry.volume;
    // The first decrement follows exactly the first retrigger.
    dec     = (rem == entry.total - 8'd1) ? entry.first_dec : entry.later_dec;
    vol_new = vol - $signed({9'd0, dec});

    entry_next           = entry;
    entry_next.countdown = cd;
    flags.emit           = 1'b0;
    flags.keep           = 1'b1;

    if (cd == 16'd0) begin
      if (!bank_loaded) begin
        flags.keep = 1'b0;
      end else begin
        flags.emit           = 1'b1;
        entry_next.remaining = rem;
        if (rem == 8'd0) begin
          flags.keep = 1'b0;
        end else begin
          entry_next.countdown = entry.reload;
          entry_next.volume    = vol_new;
          if (vol_new < VOLUME_FLOOR) begin
            flags.keep = 1'b0;
          end
        end
      end
    end
  end

endmodule

// File: tb/sound_echo_retrigger_scheduler_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sound_echo_retrigger_scheduler_tb: self-checking bench for the echo slots
// Drives create, stop, stop-all and tick commands under random stalls on
// both streams. A behavioral copy of the slot bank predicts every retrigger
// word, and each word leaving the block is compared with the oldest one.
// ---------------------------------------------------------------------------
module sound_echo_retrigger_scheduler_tb;
  import sers_pkg::*;

  localparam int SLOTS         = 16;
  localparam int BANKS         = 16;
  localparam int SETTLE_CYCLES = 24;    // a full tick walk plus the output hand-off
  localparam int STALL_LIMIT   = 2000;
  localparam int PRINT_LIMIT   = 40;
  localparam logic signed [16:0] QUIET_FLOOR = -17'sd127;

  typedef struct {
    op_t               op;
    logic [3:0]        slot;
    logic [15:0]       bank;
    logic [15:0]       code;
    logic [15:0]       interval;
    logic [7:0]        first_dec;
    logic [7:0]        later_dec;
    logic [7:0]        repeats;
    logic signed [15:0] start_vol;
  } echo_cmd_t;

  typedef struct {
    logic [3:0]  slot;
    logic [15:0] bank;
    logic [15:0] code;
    logic [15:0] volume;
    logic        last;
  } retrig_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [15:0]       cfg_wdata;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic [1:0]        s_tuser;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tlast;

  // Behavioral copy of the slot bank.
  logic [15:0]       bank_mask;
  slot_entry_t       echo_slots [SLOTS];
  logic              slot_live  [SLOTS];
  retrig_t           pending_retriggers[$];

  int send_idle_pct = 30;
  int recv_idle_pct = 71;
  int mismatches    = 0;
  int stall_cycles  = 0;

  sound_echo_retrigger_scheduler #(
    .SLOT_COUNT(SLOTS),
    .BANK_COUNT(BANKS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("MISMATCH @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  function automatic logic bank_loaded(input logic [15:0] b);
    return (b < BANKS) && bank_mask[b[3:0]];
  endfunction

  task automatic predict_echo_command(input echo_cmd_t c);
    retrig_t    burst[$];
    retrig_t    r;
    logic [7:0] first_mark;
    case (c.op)
      OP_CREATE: begin
        if (bank_loaded(c.bank)) begin
          slot_live[c.slot]            = 1'b1;
          echo_slots[c.slot].bank      = c.bank;
          echo_slots[c.slot].code      = c.code;
          echo_slots[c.slot].reload    = c.interval;
          echo_slots[c.slot].countdown = 16'd1;
          echo_slots[c.slot].first_dec = c.first_dec;
          echo_slots[c.slot].later_dec = c.later_dec;
          echo_slots[c.slot].total     = c.repeats;
          echo_slots[c.slot].remaining = c.repeats;
          echo_slots[c.slot].volume    = {c.start_vol[15], c.start_vol};
        end
      end
      OP_STOP: begin
        if (bank_loaded(c.bank)) slot_live[c.slot] = 1'b0;
      end
      OP_STOP_ALL: begin
        foreach (slot_live[i]) slot_live[i] = 1'b0;
      end
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_live[i]) continue;
          echo_slots[i].countdown = echo_slots[i].countdown - 16'd1;
          if (echo_slots[i].countdown != 16'd0) continue;
          // A bank unloaded under a running echo ends it silently.
          if (!bank_loaded(echo_slots[i].bank)) begin
            slot_live[i] = 1'b0;
            continue;
          end
          r.slot   = 4'(i);
          r.bank   = echo_slots[i].bank;
          r.code   = echo_slots[i].code;
          r.volume = echo_slots[i].volume[15:0];
          r.last   = 1'b0;
          burst.push_back(r);
          echo_slots[i].remaining = echo_slots[i].remaining - 8'd1;
          if (echo_slots[i].remaining == 8'd0) begin
            slot_live[i] = 1'b0;
            continue;
          end
          echo_slots[i].countdown = echo_slots[i].reload;
          first_mark = echo_slots[i].total - 8'd1;
          if (echo_slots[i].remaining == first_mark)
            echo_slots[i].volume = echo_slots[i].volume
                                   - $signed({9'd0, echo_slots[i].first_dec});
          else
            echo_slots[i].volume = echo_slots[i].volume
                                   - $signed({9'd0, echo_slots[i].later_dec});
          if (echo_slots[i].volume < QUIET_FLOOR) slot_live[i] = 1'b0;
        end
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[k]) pending_retriggers.push_back(burst[k]);
      end
      default: ;
    endcase
  endtask

  function automatic echo_cmd_t echo_cmd(input op_t op, input logic [3:0] slot,
      input logic [15:0] bank, input logic [15:0] code, input logic [15:0] interval,
      input logic [7:0] first_dec, input logic [7:0] later_dec,
      input logic [7:0] repeats, input logic signed [15:0] start_vol);
    echo_cmd_t c;
    c.op        = op;
    c.slot      = slot;
    c.bank      = bank;
    c.code      = code;
    c.interval  = interval;
    c.first_dec = first_dec;
    c.later_dec = later_dec;
    c.repeats   = repeats;
    c.start_vol = start_vol;
    return c;
  endfunction

  // Leaves s_tvalid high on return; the caller either sends again at once
  // or lowers it through wait_for_quiet.
  task automatic send_command(input echo_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.op;
    s_tdata  <= {4'd0, c.start_vol, c.repeats, c.later_dec, c.first_dec,
                 c.interval, c.code, c.bank, c.slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_echo_command(c);
  endtask

  task automatic send_ticks(input int n);
    repeat (n)
      send_command(echo_cmd(OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 16'($urandom)));
  endtask

  task automatic wait_for_quiet();
    s_tvalid <= 1'b0;
    while (pending_retriggers.size() != 0) @(posedge clk);
    // A tick with no word left to give may still be walking the slots.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bank_mask(input logic [15:0] mask);
    wait_for_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
    bank_mask = mask;
  endtask

  task automatic test_basic_echoes();
    write_bank_mask(16'h0000);
    send_command(echo_cmd(OP_CREATE, 4'd2, 16'd0, 16'h1111, 16'd1, 8'd0, 8'd0,
                          8'd2, 16'sd0));
    send_ticks(1);
    write_bank_mask(16'h8001);
    // Loudest start with the largest first decrement.
    send_command(echo_cmd(OP_CREATE, 4'd0, 16'd0, 16'hFFFF, 16'd1, 8'hFF, 8'h00,
                          8'd3, 16'sh7FFF));
    // Quietest start: one retrigger even though it is below the floor.
    send_command(echo_cmd(OP_CREATE, 4'd15, 16'd15, 16'h0000, 16'd2, 8'h00, 8'hFF,
                          8'd1, 16'sh8000));
    send_command(echo_cmd(OP_CREATE, 4'd4, 16'd1, 16'h2222, 16'd1, 8'd1, 8'd1,
                          8'd4, 16'sd0));
    send_command(echo_cmd(OP_CREATE, 4'd4, 16'hFFFF, 16'h3333, 16'd1, 8'd1, 8'd1,
                          8'd4, 16'sd0));
    // Interval zero reloads as a full 16-bit wrap.
    send_command(echo_cmd(OP_CREATE, 4'd5, 16'd15, 16'h1234, 16'd0, 8'd0, 8'd0,
                          8'd2, 16'sd0));
    // Sits on the floor; the first decrement pushes it under and ends it.
    send_command(echo_cmd(OP_CREATE, 4'd3, 16'd0, 16'hA5A5, 16'd1, 8'd1, 8'd0,
                          8'd255, -16'sd127));
    send_ticks(4);
    send_command(echo_cmd(OP_CREATE, 4'd9, 16'd0, 16'h5A5A, 16'd1, 8'd0, 8'd200,
                          8'd5, 16'sd100));
    send_command(echo_cmd(OP_STOP, 4'd9, 16'd1, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0,
                          16'sd0));
    send_ticks(1);
    send_command(echo_cmd(OP_STOP, 4'd9, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0,
                          16'sd0));
    send_ticks(1);
    send_command(echo_cmd(OP_STOP, 4'd5, 16'd15, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0,
                          16'sd0));
    send_command(echo_cmd(OP_STOP_ALL, 4'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0,
                          16'sd0));
    send_ticks(1);
  endtask

  task automatic test_bank_removed();
    write_bank_mask(16'hFFFF);
    send_command(echo_cmd(OP_CREATE, 4'd7, 16'd0, 16'h0707, 16'd3, 8'd0, 8'd0,
                          8'd0, 16'sd0));
    send_command(echo_cmd(OP_CREATE, 4'd8, 16'd2, 16'h0808, 16'd1, 8'd3, 8'd3,
                          8'd4, 16'sd20));
    send_ticks(2);
    write_bank_mask(16'hFFFA);
    send_ticks(4);
  endtask

  task automatic test_repeat_wrap();
    write_bank_mask(16'hFFFF);
    // A repeat count of zero gives 256 retriggers.
    send_command(echo_cmd(OP_CREATE, 4'd11, 16'd3, 16'hC0DE, 16'd1, 8'd0, 8'd0,
                          8'd0, -16'sd5));
    send_ticks(258);
  endtask

  task automatic test_random(input int sender_idle, input int receiver_idle,
                             input int count);
    echo_cmd_t c;
    int        pick;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    repeat (count) begin
      pick = $urandom_range(99);
      c = echo_cmd(OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom));
      c.op = (pick < 55) ? OP_TICK : (pick < 80) ? OP_CREATE :
             (pick < 96) ? OP_STOP : OP_STOP_ALL;
      if (c.op != OP_TICK) begin
        // Mostly in-range banks, short intervals and short runs so that
        // echoes play out; the rest spans the full field ranges.
        if ($urandom_range(9) < 8) c.bank = 16'($urandom_range(BANKS - 1));
        if ($urandom_range(19) != 0) c.interval = 16'($urandom_range(4, 1));
        if ($urandom_range(9) != 0) c.repeats = 8'($urandom_range(6, 1));
        if ($urandom_range(3) != 0) c.first_dec = 8'($urandom_range(40));
        if ($urandom_range(3) != 0) c.later_dec = 8'($urandom_range(40));
        if ($urandom_range(3) != 0) c.start_vol = 16'($urandom_range(400)) - 16'd150;
      end
      send_command(c);
    end
  endtask

  always @(posedge clk) begin
    retrig_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_retriggers.size() == 0) begin
        report_mismatch("retrigger word with none expected", m_tdata[31:0], 32'd0);
      end else begin
        want = pending_retriggers.pop_front();
        if (m_tdata[3:0] !== want.slot)
          report_mismatch("out_slot", 32'(m_tdata[3:0]), 32'(want.slot));
        if (m_tdata[19:4] !== want.bank)
          report_mismatch("out_bank", 32'(m_tdata[19:4]), 32'(want.bank));
        if (m_tdata[35:20] !== want.code)
          report_mismatch("out_code", 32'(m_tdata[35:20]), 32'(want.code));
        if (m_tdata[51:36] !== want.volume)
          report_mismatch("out_volume", 32'(m_tdata[51:36]), 32'(want.volume));
        if (m_tlast !== want.last)
          report_mismatch("m_tlast", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  // Ends the run when neither stream moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("sound_echo_retrigger_scheduler verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    retrig_t left;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 16'd0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_TICK;
    bank_mask = 16'd0;
    foreach (slot_live[i]) begin
      slot_live[i]  = 1'b0;
      echo_slots[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_basic_echoes();
    test_bank_removed();
    test_repeat_wrap();
    write_bank_mask(16'($urandom));
    test_random(30, 71, 28);
    write_bank_mask(16'hFFFF);
    test_random(71, 30, 28);
    write_bank_mask(16'($urandom) | 16'h00F0);
    test_random(0, 0, 28);

    wait_for_quiet();
    while (pending_retriggers.size() != 0) begin
      left = pending_retriggers.pop_front();
      report_mismatch("retrigger never seen for slot", 32'd0, 32'(left.slot));
    end
    if (mismatches == 0) begin
      $display("sound_echo_retrigger_scheduler verification clean");
    end else begin
      $display("sound_echo_retrigger_scheduler verification failed");
    end
    $finish;
  end

endmodule
